### hw/rtl/rgbf_pkg.sv
// types and constants for the rgb fade pwm generator
// used by rgb_fade_pwm_generator and tb_top, depends on nothing
package rgbf_pkg;

  localparam int unsigned LevelW = 4;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned LedW = 8;

  localparam logic [LevelW-1:0] LevelMax = 4'hf;
  localparam logic [LevelW-1:0] LevelMin = 4'h0;
  localparam logic [CountW-1:0] FadeIntervalRst = 8'd100;

  typedef enum logic [2:0] {
    FADE_ADD_RED,
    FADE_ADD_GREEN,
    FADE_DEL_RED,
    FADE_ADD_BLUE,
    FADE_DEL_GREEN,
    FADE_READD_RED,
    FADE_DEL_BLUE
  } fade_phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FADE_INTERVAL,
    CFG_BACKLIGHT_ON,
    CFG_SPARE_BIT_FOUR
  } cfg_idx_e;

endpackage

### hw/rtl/rgb_fade_pwm_generator.sv
// rgb fade pwm generator: pwm phase, tick counter, fade sequencer, led byte
// depends on rgbf_pkg
//
// usage:
//   input channel (in_valid_i/in_ready_o, tick_i) takes one timer tick per item.
//   each accepted item yields exactly one result on the output channel
//   (out_valid_o/out_ready_i) with the active-low led byte, the three colour
//   levels and the pwm phase after that tick's update.
//   a zero tick leaves the state unchanged and still yields a result.
//   the result is registered and valid in the cycle after acceptance.
//   throughput: one item per cycle; the single output register is refilled in
//   the same cycle it is drained, so in_ready_o is low only while a result
//   waits and out_ready_i is low.
//   configuration (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is always
//   ready; index 0 fade interval, 1 backlight bit, 2 spare bit four, others
//   ignored. write only while idle.
//   reset: phase, counter and levels clear to zero, sequencer starts with the
//   red ramp, fade interval 100, backlight 0, spare bit 1, no result pending.
module rgb_fade_pwm_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           tick_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rgbf_pkg::LedW-1:0]      led_byte_o,
  output logic [rgbf_pkg::LevelW-1:0]    red_level_o,
  output logic [rgbf_pkg::LevelW-1:0]    green_level_o,
  output logic [rgbf_pkg::LevelW-1:0]    blue_level_o,
  output logic [rgbf_pkg::LevelW-1:0]    pwm_phase_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rgbf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rgbf_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rgbf_pkg::*;

  logic [CountW-1:0] fade_interval_q;
  logic              backlight_on_q;
  logic              spare_bit_four_q;

  logic [LevelW-1:0] pwm_phase_q, pwm_phase_d;
  logic [CountW-1:0] tick_count_q, tick_count_d;
  logic [LevelW-1:0] red_q, red_d;
  logic [LevelW-1:0] green_q, green_d;
  logic [LevelW-1:0] blue_q, blue_d;
  fade_phase_e       fade_phase_q, fade_phase_d;

  logic              out_valid_q, out_valid_d;
  logic [LedW-1:0]   led_q, led_d;
  logic [LevelW-1:0] red_out_q, green_out_q, blue_out_q, phase_out_q;

  logic              in_acc;
  logic [CountW-1:0] count_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign in_acc      = in_valid_i & in_ready_o;
  assign count_inc   = tick_count_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_interval_q  <= FadeIntervalRst;
      backlight_on_q   <= 1'b0;
      spare_bit_four_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FADE_INTERVAL:  fade_interval_q  <= cfg_data_i;
        CFG_BACKLIGHT_ON:   backlight_on_q   <= cfg_data_i[0];
        CFG_SPARE_BIT_FOUR: spare_bit_four_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // state update and sequencer step
  always_comb begin
    pwm_phase_d  = pwm_phase_q;
    tick_count_d = tick_count_q;
    red_d        = red_q;
    green_d      = green_q;
    blue_d       = blue_q;
    fade_phase_d = fade_phase_q;
    if (in_acc && tick_i) begin
      pwm_phase_d  = pwm_phase_q + 4'd1;
      tick_count_d = count_inc;
      if (count_inc == fade_interval_q) begin
        tick_count_d = '0;
        unique case (fade_phase_q)
          FADE_ADD_RED: begin
            if (red_q != LevelMax) begin
              red_d = red_q + 4'd1;
            end else if (green_q != LevelMax) begin
              green_d      = green_q + 4'd1;
              fade_phase_d = FADE_ADD_GREEN;
            end else begin
              fade_phase_d = FADE_DEL_RED;
            end
          end
          FADE_ADD_GREEN: begin
            if (green_q != LevelMax) green_d = green_q + 4'd1;
            else fade_phase_d = FADE_DEL_RED;
          end
          FADE_DEL_RED: begin
            if (red_q != LevelMin) red_d = red_q - 4'd1;
            else fade_phase_d = FADE_ADD_BLUE;
          end
          FADE_ADD_BLUE: begin
            if (blue_q != LevelMax) blue_d = blue_q + 4'd1;
            else fade_phase_d = FADE_DEL_GREEN;
          end
          FADE_DEL_GREEN: begin
            if (green_q != LevelMin) green_d = green_q - 4'd1;
            else fade_phase_d = FADE_READD_RED;
          end
          FADE_READD_RED: begin
            if (red_q != LevelMax) red_d = red_q + 4'd1;
            else fade_phase_d = FADE_DEL_BLUE;
          end
          FADE_DEL_BLUE: begin
            if (blue_q != LevelMin) blue_d = blue_q - 4'd1;
            else fade_phase_d = FADE_ADD_GREEN;
          end
          default: ;
        endcase
      end
    end
  end

  // active-low led byte from the updated levels and phase, plus backlight and spare bits
  always_comb begin
    led_d    = '0;
    led_d[0] = backlight_on_q;
    led_d[1] = (red_d <= pwm_phase_d);
    led_d[2] = (green_d <= pwm_phase_d);
    led_d[3] = (blue_d <= pwm_phase_d);
    led_d[4] = spare_bit_four_q;
    led_d[5] = (blue_d <= pwm_phase_d);
    led_d[6] = (green_d <= pwm_phase_d);
    led_d[7] = (red_d <= pwm_phase_d);
  end

  assign out_valid_d = in_acc | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_phase_q  <= '0;
      tick_count_q <= '0;
      red_q        <= '0;
      green_q      <= '0;
      blue_q       <= '0;
      fade_phase_q <= FADE_ADD_RED;
      out_valid_q  <= 1'b0;
    end else begin
      pwm_phase_q  <= pwm_phase_d;
      tick_count_q <= tick_count_d;
      red_q        <= red_d;
      green_q      <= green_d;
      blue_q       <= blue_d;
      fade_phase_q <= fade_phase_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      led_q       <= led_d;
      red_out_q   <= red_d;
      green_out_q <= green_d;
      blue_out_q  <= blue_d;
      phase_out_q <= pwm_phase_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign led_byte_o      = led_q;
  assign red_level_o     = red_out_q;
  assign green_level_o   = green_out_q;
  assign blue_level_o    = blue_out_q;
  assign pwm_phase_out_o = phase_out_q;

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for rgb_fade_pwm_generator: directed table, then random ticks
// predicts every led frame from its own copy of the fade state, depends on rgbf_pkg
module tb_top;
  import rgbf_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 4;

  typedef struct packed {
    logic [LedW-1:0]   led;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
    logic [LevelW-1:0] phase;
  } led_frame_t;

  typedef enum logic {
    ROW_TICK,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
    logic                tick;
    logic                typed;
    led_frame_t          want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                tick_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [LedW-1:0]     led_byte_o;
  logic [LevelW-1:0]   red_level_o;
  logic [LevelW-1:0]   green_level_o;
  logic [LevelW-1:0]   blue_level_o;
  logic [LevelW-1:0]   pwm_phase_out_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_FADE_INTERVAL;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  rgb_fade_pwm_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .tick_i         (tick_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .led_byte_o     (led_byte_o),
    .red_level_o    (red_level_o),
    .green_level_o  (green_level_o),
    .blue_level_o   (blue_level_o),
    .pwm_phase_out_o(pwm_phase_out_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic [LevelW-1:0]   pwm_q;
  logic [LevelW-1:0]   red_q;
  logic [LevelW-1:0]   green_q;
  logic [LevelW-1:0]   blue_q;
  logic [CountW-1:0]   tick_cnt_q;
  logic [CountW-1:0]   fade_interval_q;
  logic                backlight_q;
  logic                spare_q;
  fade_phase_e         fade_q;

  led_frame_t          frames_pending[$];
  led_frame_t          head_frame;
  stim_row_t           dir_rows[$];
  int unsigned         err_cnt = 0;
  int unsigned         ticks_sent = 0;
  int unsigned         zero_ticks = 0;
  int unsigned         frames_seen = 0;
  int unsigned         writes_done = 0;
  int unsigned         fade_steps = 0;
  int unsigned         stall_cycles = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;

  function automatic void fade_step();
    fade_steps++;
    case (fade_q)
      FADE_ADD_RED: begin
        if (red_q != LevelMax) red_q = red_q + 1'b1;
        else if (green_q != LevelMax) begin
          // red already full: fall through into the green ramp
          green_q = green_q + 1'b1;
          fade_q = FADE_ADD_GREEN;
        end else fade_q = FADE_DEL_RED;
      end
      FADE_ADD_GREEN: begin
        if (green_q != LevelMax) green_q = green_q + 1'b1;
        else fade_q = FADE_DEL_RED;
      end
      FADE_DEL_RED: begin
        if (red_q != LevelMin) red_q = red_q - 1'b1;
        else fade_q = FADE_ADD_BLUE;
      end
      FADE_ADD_BLUE: begin
        if (blue_q != LevelMax) blue_q = blue_q + 1'b1;
        else fade_q = FADE_DEL_GREEN;
      end
      FADE_DEL_GREEN: begin
        if (green_q != LevelMin) green_q = green_q - 1'b1;
        else fade_q = FADE_READD_RED;
      end
      FADE_READD_RED: begin
        if (red_q != LevelMax) red_q = red_q + 1'b1;
        else fade_q = FADE_DEL_BLUE;
      end
      FADE_DEL_BLUE: begin
        if (blue_q != LevelMin) blue_q = blue_q - 1'b1;
        else fade_q = FADE_ADD_GREEN;
      end
      default: ;
    endcase
  endfunction

  function automatic led_frame_t predict_frame(input logic t);
    led_frame_t f;
    if (t) begin
      pwm_q = pwm_q + 1'b1;
      tick_cnt_q = tick_cnt_q + 1'b1;
      if (tick_cnt_q == fade_interval_q) begin
        tick_cnt_q = '0;
        fade_step();
      end
    end
    f.led = {(red_q <= pwm_q), (green_q <= pwm_q), (blue_q <= pwm_q), spare_q,
             (blue_q <= pwm_q), (green_q <= pwm_q), (red_q <= pwm_q), backlight_q};
    f.red = red_q;
    f.green = green_q;
    f.blue = blue_q;
    f.phase = pwm_q;
    return f;
  endfunction

  function automatic stim_row_t tick_row(input logic t, input logic typed,
                                         input led_frame_t want);
    stim_row_t r;
    r.kind = ROW_TICK;
    r.idx = CFG_FADE_INTERVAL;
    r.data = '0;
    r.tick = t;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = val;
    r.tick = 1'b0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic send_tick(input logic t, input logic typed, input led_frame_t want);
    led_frame_t f;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    f = predict_frame(t);
    frames_pending.push_back(typed ? want : f);
    ticks_sent++;
    if (!t) zero_ticks++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    in_valid_i <= 1'b0;
    while (frames_pending.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FADE_INTERVAL:  fade_interval_q = val;
      CFG_BACKLIGHT_ON:   backlight_q = val[0];
      CFG_SPARE_BIT_FOUR: spare_q = val[0];
      default: ;
    endcase
    writes_done++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      frames_seen++;
      if (frames_pending.size() == 0) begin
        $error("unexpected result: led_byte %h", led_byte_o);
        err_cnt++;
      end else begin
        head_frame = frames_pending.pop_front();
        if (led_byte_o !== head_frame.led) begin
          $error("led_byte: expected %h, actual %h", head_frame.led, led_byte_o);
          err_cnt++;
        end
        if (red_level_o !== head_frame.red) begin
          $error("red_level: expected %0d, actual %0d", head_frame.red, red_level_o);
          err_cnt++;
        end
        if (green_level_o !== head_frame.green) begin
          $error("green_level: expected %0d, actual %0d", head_frame.green, green_level_o);
          err_cnt++;
        end
        if (blue_level_o !== head_frame.blue) begin
          $error("blue_level: expected %0d, actual %0d", head_frame.blue, blue_level_o);
          err_cnt++;
        end
        if (pwm_phase_out_o !== head_frame.phase) begin
          $error("pwm_phase_out: expected %0d, actual %0d", head_frame.phase,
                 pwm_phase_out_o);
          err_cnt++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("watchdog: no handshake for %0d cycles", stall_cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    stim_row_t           row;
    int unsigned         k;
    int unsigned         j;
    int unsigned         ph;
    int unsigned         n_items;
    int unsigned         zero_pct;
    logic [CfgDataW-1:0] interval;
    logic                t;

    pwm_q = '0;
    red_q = '0;
    green_q = '0;
    blue_q = '0;
    tick_cnt_q = '0;
    fade_interval_q = FadeIntervalRst;
    backlight_q = 1'b0;
    spare_q = 1'b1;
    fade_q = FADE_ADD_RED;

    // reset state, then both spare outputs flipped
    dir_rows.push_back(tick_row(1'b0, 1'b1, {8'hfe, 4'h0, 4'h0, 4'h0, 4'h0}));
    dir_rows.push_back(cfg_row(CFG_BACKLIGHT_ON, 8'd1));
    dir_rows.push_back(cfg_row(CFG_SPARE_BIT_FOUR, 8'd0));
    dir_rows.push_back(tick_row(1'b0, 1'b1, {8'hef, 4'h0, 4'h0, 4'h0, 4'h0}));
    // step every tick: red ramps to full, then falls through into green
    dir_rows.push_back(cfg_row(CFG_FADE_INTERVAL, 8'd1));
    dir_rows.push_back(tick_row(1'b1, 1'b1, {8'hef, 4'h1, 4'h0, 4'h0, 4'h1}));
    for (k = 0; k < 15; k++) dir_rows.push_back(tick_row(1'b1, 1'b0, '0));
    dir_rows.push_back(tick_row(1'b0, 1'b0, '0));
    dir_rows.push_back(tick_row(1'b1, 1'b0, '0));
    dir_rows.push_back(tick_row(1'b1, 1'b0, '0));

    send_idle_pct = 33;
    recv_idle_pct = 56;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < dir_rows.size(); k++) begin
      row = dir_rows[k];
      if (row.kind == ROW_CFG) write_reg(row.idx, row.data);
      else send_tick(row.tick, row.typed, row.want);
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          interval = 8'd1;
          n_items = 170;
          zero_pct = 10;
        end
        1: begin
          interval = 8'd255;
          n_items = 40;
          zero_pct = 10;
          send_idle_pct = 56;
          recv_idle_pct = 33;
        end
        2: begin
          // zero interval, below the running count: counter wraps through 255
          interval = 8'd0;
          n_items = 240;
          zero_pct = 5;
        end
        default: begin
          interval = 8'($urandom_range(30, 20));
          n_items = 200;
          zero_pct = 10;
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(CFG_FADE_INTERVAL, interval);
      write_reg(CFG_BACKLIGHT_ON, 8'($urandom_range(1)));
      write_reg(CFG_SPARE_BIT_FOUR, 8'($urandom_range(1)));
      for (j = 0; j < n_items; j++) begin
        if (ph == 0 && j == n_items / 2) begin
          // hold off until the output side has drained
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (frames_pending.size() != 0);
        end
        t = ($urandom_range(99) >= zero_pct);
        send_tick(t, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (frames_pending.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d ticks (%0d zero ticks), %0d register writes, %0d fade steps",
             ticks_sent, zero_ticks, writes_done, fade_steps);
    $display("checked %0d led frames over three handshake idling profiles", frames_seen);
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
